>>> rtl/core/tmp_pkg.sv
package tmp_pkg;

    localparam int WORD_W = 64;
    typedef logic signed [WORD_W-1:0] t_word;

    // internal values saturate at +-2^61
    localparam t_word WLIM = 64'sh2000_0000_0000_0000;
    localparam logic [WORD_W-1:0] WLIM_U = 64'h2000_0000_0000_0000;
    localparam logic signed [WORD_W:0] WLIM_X = 65'sh0_2000_0000_0000_0000;

    // quotient bits resolved by the divider, one per stage
    localparam int QUOT_BITS = 62;
    localparam int MD_LAT = QUOT_BITS + 5;
    // fixed-point multiply: magnitudes, partial products, sum, scale
    localparam int MQ_LAT = 4;

    localparam logic [1:0] CFG_MAX_VEL = 2'd0;
    localparam logic [1:0] CFG_MAX_ACC = 2'd1;

    localparam logic [1:0] ST_ACCEL = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_DECEL = 2'd2;
    localparam logic [1:0] ST_GOAL  = 2'd3;

    function automatic t_word clampw(input logic signed [WORD_W:0] x);
        t_word r;
        if (x > WLIM_X) begin
            r = WLIM;
        end else if (x < -WLIM_X) begin
            r = -WLIM;
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_word addw(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        s = signed'({a[WORD_W-1], a}) + signed'({b[WORD_W-1], b});
        return clampw(s);
    endfunction

    function automatic t_word subw(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        s = signed'({a[WORD_W-1], a}) - signed'({b[WORD_W-1], b});
        return clampw(s);
    endfunction

    // halve, truncating toward zero
    function automatic t_word half(input t_word x);
        t_word adj;
        adj = t_word'({{(WORD_W-1){1'b0}}, x[WORD_W-1]});
        return (x + adj) >>> 1;
    endfunction

endpackage

>>> rtl/core/tmp_delay.sv
module tmp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic             r_valid [0:DEPTH-1];
    logic [WIDTH-1:0] r_data  [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (k == 0) begin
                r_valid[k] <= i_valid;
            end else begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (k == 0) begin
                r_data[k] <= i_data;
            end else begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

>>> rtl/core/tmp_muldiv.sv
module tmp_muldiv (
    input  logic           i_clk,
    input  tmp_pkg::t_word i_a,
    input  tmp_pkg::t_word i_b,
    input  logic [63:0]    i_d,
    output tmp_pkg::t_word o_q
);
    import tmp_pkg::*;

    localparam int HW = WORD_W / 2;

    // magnitudes and sign
    logic [WORD_W-1:0] r_am, r_bm, r_d_a;
    logic              r_neg_a;
    // partial products
    logic [WORD_W-1:0] r_pp [4];
    logic [WORD_W-1:0] r_d_b;
    logic              r_neg_b;
    // full product
    logic [2*WORD_W-1:0] r_p;
    logic [WORD_W-1:0]   r_d_c;
    logic                r_neg_c;
    // divider stages
    logic [WORD_W-1:0]    r_rem [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] r_q   [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] r_low [0:QUOT_BITS];
    logic [WORD_W-1:0]    r_dd  [0:QUOT_BITS];
    logic                 r_ng  [0:QUOT_BITS];
    logic                 r_st  [0:QUOT_BITS];
    t_word                r_out;

    logic [WORD_W:0]      n_sh  [0:QUOT_BITS-1];
    logic                 n_ge  [0:QUOT_BITS-1];
    logic [WORD_W-1:0]    n_rem [0:QUOT_BITS-1];
    logic [WORD_W-1:0]    n_qz;
    logic [WORD_W-1:0]    n_qs;
    logic                 n_sat;

    always_comb begin
        for (int k = 0; k < QUOT_BITS; k++) begin
            n_sh[k]  = {r_rem[k], r_low[k][QUOT_BITS-1]};
            n_ge[k]  = n_sh[k] >= {1'b0, r_dd[k]};
            n_rem[k] = n_ge[k] ? WORD_W'(n_sh[k] - {1'b0, r_dd[k]}) : n_sh[k][WORD_W-1:0];
        end
        n_qz = {{(WORD_W-QUOT_BITS){1'b0}}, r_q[QUOT_BITS]};
        n_qs = (r_st[QUOT_BITS] || n_qz > WLIM_U) ? WLIM_U : n_qz;
        n_sat = r_p[2*WORD_W-1:QUOT_BITS] >= {{(WORD_W-QUOT_BITS){1'b0}}, r_d_c};
    end

    always_ff @(posedge i_clk) begin
        r_am    <= i_a[WORD_W-1] ? unsigned'(-i_a) : unsigned'(i_a);
        r_bm    <= i_b[WORD_W-1] ? unsigned'(-i_b) : unsigned'(i_b);
        r_d_a   <= i_d;
        r_neg_a <= i_a[WORD_W-1] ^ i_b[WORD_W-1];

        r_pp[0] <= r_am[HW-1:0]      * r_bm[HW-1:0];
        r_pp[1] <= r_am[HW-1:0]      * r_bm[WORD_W-1:HW];
        r_pp[2] <= r_am[WORD_W-1:HW] * r_bm[HW-1:0];
        r_pp[3] <= r_am[WORD_W-1:HW] * r_bm[WORD_W-1:HW];
        r_d_b   <= r_d_a;
        r_neg_b <= r_neg_a;

        r_p <= (2*WORD_W)'(r_pp[0])
             + ((2*WORD_W)'(r_pp[1]) << HW)
             + ((2*WORD_W)'(r_pp[2]) << HW)
             + ((2*WORD_W)'(r_pp[3]) << WORD_W);
        r_d_c   <= r_d_b;
        r_neg_c <= r_neg_b;

        // upper bits already at or above the divisor mean the quotient overflows
        r_rem[0] <= r_p[WORD_W+QUOT_BITS-1:QUOT_BITS];
        r_q[0]   <= '0;
        r_low[0] <= r_p[QUOT_BITS-1:0];
        r_dd[0]  <= r_d_c;
        r_ng[0]  <= r_neg_c;
        r_st[0]  <= n_sat;

        for (int k = 0; k < QUOT_BITS; k++) begin
            r_rem[k+1] <= n_rem[k];
            r_q[k+1]   <= {r_q[k][QUOT_BITS-2:0], n_ge[k]};
            r_low[k+1] <= r_low[k] << 1;
            r_dd[k+1]  <= r_dd[k];
            r_ng[k+1]  <= r_ng[k];
            r_st[k+1]  <= r_st[k];
        end

        r_out <= r_ng[QUOT_BITS] ? -signed'(n_qs) : signed'(n_qs);
    end

    assign o_q = r_out;

endmodule

// fixed-point product: sign(a*b) * (|a||b| >> FRAC_BITS), saturated
module tmp_mulq #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  tmp_pkg::t_word i_a,
    input  tmp_pkg::t_word i_b,
    output tmp_pkg::t_word o_q
);
    import tmp_pkg::*;

    localparam int HW = WORD_W / 2;

    logic [WORD_W-1:0]   r_am, r_bm;
    logic                r_neg_a;
    logic [WORD_W-1:0]   r_pp [4];
    logic                r_neg_b;
    logic [2*WORD_W-1:0] r_p;
    logic                r_neg_c;
    t_word               r_out;

    logic [2*WORD_W-1:0] n_sh;
    logic [WORD_W-1:0]   n_qs;

    always_comb begin
        n_sh = r_p >> FRAC_BITS;
        n_qs = (n_sh > (2*WORD_W)'(WLIM_U)) ? WLIM_U : n_sh[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_am    <= i_a[WORD_W-1] ? unsigned'(-i_a) : unsigned'(i_a);
        r_bm    <= i_b[WORD_W-1] ? unsigned'(-i_b) : unsigned'(i_b);
        r_neg_a <= i_a[WORD_W-1] ^ i_b[WORD_W-1];

        r_pp[0] <= r_am[HW-1:0]      * r_bm[HW-1:0];
        r_pp[1] <= r_am[HW-1:0]      * r_bm[WORD_W-1:HW];
        r_pp[2] <= r_am[WORD_W-1:HW] * r_bm[HW-1:0];
        r_pp[3] <= r_am[WORD_W-1:HW] * r_bm[WORD_W-1:HW];
        r_neg_b <= r_neg_a;

        r_p <= (2*WORD_W)'(r_pp[0])
             + ((2*WORD_W)'(r_pp[1]) << HW)
             + ((2*WORD_W)'(r_pp[2]) << HW)
             + ((2*WORD_W)'(r_pp[3]) << WORD_W);
        r_neg_c <= r_neg_b;

        r_out <= r_neg_c ? -signed'(n_qs) : signed'(n_qs);
    end

    assign o_q = r_out;

endmodule

>>> rtl/core/tmp_sqrt.sv
module tmp_sqrt #(
    parameter int FRAC_BITS = 16,
    parameter int ROOT_BITS = 39
) (
    input  logic           i_clk,
    input  tmp_pkg::t_word i_q,
    output tmp_pkg::t_word o_root
);
    import tmp_pkg::*;

    localparam int XW = 2 * ROOT_BITS;
    localparam int RW = ROOT_BITS + 2;

    logic [XW-1:0]        r_x    [0:ROOT_BITS];
    logic [RW-1:0]        r_rem  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] r_root [0:ROOT_BITS];
    t_word                r_out;

    logic [RW+1:0] n_tr    [0:ROOT_BITS-1];
    logic [RW+1:0] n_trial [0:ROOT_BITS-1];
    logic          n_ge    [0:ROOT_BITS-1];

    always_comb begin
        for (int k = 0; k < ROOT_BITS; k++) begin
            n_tr[k]    = {r_rem[k], r_x[k][XW-1 -: 2]};
            n_trial[k] = (RW+2)'({r_root[k], 2'b01});
            n_ge[k]    = n_tr[k] >= n_trial[k];
        end
    end

    always_ff @(posedge i_clk) begin
        // a non-positive operand gives a zero root
        r_x[0]    <= (i_q <= 0) ? '0 : (XW'(unsigned'(i_q)) << FRAC_BITS);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        for (int k = 0; k < ROOT_BITS; k++) begin
            r_x[k+1]    <= r_x[k] << 2;
            r_rem[k+1]  <= n_ge[k] ? RW'(n_tr[k] - n_trial[k]) : RW'(n_tr[k]);
            r_root[k+1] <= {r_root[k][ROOT_BITS-2:0], n_ge[k]};
        end
        r_out <= t_word'(r_root[ROOT_BITS]);
    end

    assign o_root = r_out;

endmodule

>>> rtl/core/trapezoid_motion_profile_step.sv
// Trapezoidal motion profile evaluator, fully pipelined.
// Query channel: present elapsed time, goal and start state with start high;
// a query is taken on each rising edge where start is high and busy is low.
// busy is high only while reset is asserted, so one query can enter per cycle.
// Result channel: o_done is high for exactly one cycle with the profiled
// position, velocity and stage; the receiver must take it in that cycle.
// The result strobe and outputs are registered. The path runs through two
// chained multiply-divide pipelines of 67 stages (62 one-bit divide steps),
// the one-bit-per-stage square root and two chained 4-stage fixed-point
// multiplies. Throughput is one query per cycle.
// Limits are written through i_cfg_valid / o_cfg_ready with a register index
// (0 max velocity, 1 max acceleration); write only while no query is in
// flight. Reset (synchronous, active low) clears the pipeline valids and sets
// both limits to 1.0.
module trapezoid_motion_profile_step #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [DATA_WIDTH-2:0]        i_elapsed_time,
    input  logic signed [DATA_WIDTH-1:0] i_goal_position,
    input  logic signed [DATA_WIDTH-1:0] i_goal_velocity,
    input  logic signed [DATA_WIDTH-1:0] i_current_position,
    input  logic signed [DATA_WIDTH-1:0] i_current_velocity,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [DATA_WIDTH-1:0]        i_cfg_data,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_next_position,
    output logic signed [DATA_WIDTH-1:0] o_next_velocity,
    output logic [1:0]                   o_stage
);
    import tmp_pkg::*;

    localparam int ROOT_BITS = (63 + FRAC_BITS) / 2;
    localparam int SQ_LAT    = ROOT_BITS + 2;
    localparam t_word ONE    = t_word'(64'd1 << FRAC_BITS);
    localparam logic [DATA_WIDTH-2:0] CFG_RST = (DATA_WIDTH-1)'(64'd1 << FRAC_BITS);
    localparam t_word OUT_MAX = t_word'((64'd1 << (DATA_WIDTH-1)) - 64'd1);
    localparam t_word OUT_MIN = -OUT_MAX - t_word'(1);

    typedef struct packed {
        logic       flip;
        t_word      t;
        t_word      gp;
        t_word      gv;
        t_word      cp;
        t_word      cv;
        t_word      vel;
        t_word      acc;
        t_word      tb;
        t_word      te;
        t_word      ta;
        t_word      full_dist;
        t_word      fs;
        logic       neg;
        t_word      fq;
        t_word      ea;
        t_word      ef;
        t_word      ed;
        t_word      rem;
        t_word      tmea;
        logic [1:0] stg;
        t_word      m2;
        t_word      m3;
        t_word      s0v;
        t_word      s0sum;
        t_word      s1sum;
        t_word      s2v;
        t_word      s2sum;
        t_word      pos;
        t_word      vout;
    } t_job;

    localparam int JW = $bits(t_job);

    logic [DATA_WIDTH-2:0] r_max_vel, r_max_acc;
    t_word vel_eff, acc_eff;

    t_job r_j0, r_j2, r_j5, r_j6, r_j7, r_j8, r_j10, r_j12;
    t_job n_j0, n_j2, n_j3f, n_j5, n_j6, n_j7, n_j8, n_j10, n_j12;
    logic r_v0, r_v2, r_v5, r_v6, r_v7, r_v8, r_v10, r_v12, r_done;
    t_job j1, j3, j4, j9, j11;
    logic v1, v3, v4, v9, v11;

    t_word tb_q, db_q, te_q, de_q, ta_q, vv_q;
    t_word dq_q, fq_q, sq_q;
    t_word m1_q, m2_q, m3_q, m4_q;
    t_word n0_q, n1_q, n2_q;

    t_word n_pf, n_vf;
    logic signed [DATA_WIDTH-1:0] n_po, n_vo;
    logic signed [DATA_WIDTH-1:0] r_po, r_vo;
    logic [1:0] r_stg;

    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;

    // a zero limit is used as the smallest step
    assign vel_eff = (r_max_vel == '0) ? t_word'(1) : t_word'(r_max_vel);
    assign acc_eff = (r_max_acc == '0) ? t_word'(1) : t_word'(r_max_acc);

    // input stage: mirror a downward move so the plan is always upward, and clamp the start velocity to the limit
    always_comb begin
        n_j0 = '0;
        n_j0.flip = i_current_position > i_goal_position;
        n_j0.t    = t_word'(i_elapsed_time);
        if (n_j0.flip) begin
            n_j0.gp = -t_word'(i_goal_position);
            n_j0.gv = -t_word'(i_goal_velocity);
            n_j0.cp = -t_word'(i_current_position);
            n_j0.cv = -t_word'(i_current_velocity);
        end else begin
            n_j0.gp = t_word'(i_goal_position);
            n_j0.gv = t_word'(i_goal_velocity);
            n_j0.cp = t_word'(i_current_position);
            n_j0.cv = t_word'(i_current_velocity);
        end
        n_j0.vel = vel_eff;
        n_j0.acc = acc_eff;
        if (n_j0.cv > vel_eff) begin
            n_j0.cv = vel_eff;
        end
    end

    // cutoff times and distances, accel time and V*V/A
    tmp_muldiv u_md_tb (.i_clk, .i_a(r_j0.cv), .i_b(ONE), .i_d(unsigned'(r_j0.acc)),
                        .o_q(tb_q));
    tmp_muldiv u_md_db (.i_clk, .i_a(r_j0.cv), .i_b(r_j0.cv),
                        .i_d({r_j0.acc[62:0], 1'b0}), .o_q(db_q));
    tmp_muldiv u_md_te (.i_clk, .i_a(r_j0.gv), .i_b(ONE), .i_d(unsigned'(r_j0.acc)),
                        .o_q(te_q));
    tmp_muldiv u_md_de (.i_clk, .i_a(r_j0.gv), .i_b(r_j0.gv),
                        .i_d({r_j0.acc[62:0], 1'b0}), .o_q(de_q));
    tmp_muldiv u_md_ta (.i_clk, .i_a(r_j0.vel), .i_b(ONE), .i_d(unsigned'(r_j0.acc)),
                        .o_q(ta_q));
    tmp_muldiv u_md_vv (.i_clk, .i_a(r_j0.vel), .i_b(r_j0.vel),
                        .i_d(unsigned'(r_j0.acc)), .o_q(vv_q));

    tmp_delay #(.WIDTH(JW), .DEPTH(MD_LAT)) u_dl1 (
        .i_clk, .i_rst_n, .i_valid(r_v0), .i_data(r_j0), .o_valid(v1), .o_data(j1)
    );

    always_comb begin
        n_j2           = j1;
        n_j2.tb        = tb_q;
        n_j2.te        = te_q;
        n_j2.ta        = ta_q;
        n_j2.full_dist = addw(addw(db_q, subw(j1.gp, j1.cp)), de_q);
        n_j2.fs        = subw(n_j2.full_dist, vv_q);
        n_j2.neg       = n_j2.fs < 0;
    end

    // triangle fallback operand and cruise time
    tmp_muldiv u_md_dq (.i_clk, .i_a(r_j2.full_dist), .i_b(ONE),
                        .i_d(unsigned'(r_j2.acc)), .o_q(dq_q));
    tmp_muldiv u_md_fq (.i_clk, .i_a(r_j2.neg ? t_word'(0) : r_j2.fs), .i_b(ONE),
                        .i_d(unsigned'(r_j2.vel)), .o_q(fq_q));

    tmp_delay #(.WIDTH(JW), .DEPTH(MD_LAT)) u_dl2 (
        .i_clk, .i_rst_n, .i_valid(r_v2), .i_data(r_j2), .o_valid(v3), .o_data(j3)
    );

    always_comb begin
        n_j3f    = j3;
        n_j3f.fq = fq_q;
    end

    tmp_sqrt #(.FRAC_BITS(FRAC_BITS), .ROOT_BITS(ROOT_BITS)) u_sqrt (
        .i_clk, .i_q(dq_q), .o_root(sq_q)
    );

    tmp_delay #(.WIDTH(JW), .DEPTH(SQ_LAT)) u_dl3 (
        .i_clk, .i_rst_n, .i_valid(v3), .i_data(n_j3f), .o_valid(v4), .o_data(j4)
    );

    // stage end times with clamped adds and subtracts, then the remaining times and the profile stage
    always_comb begin
        n_j5    = j4;
        n_j5.ta = j4.neg ? sq_q : j4.ta;
        n_j5.ea = subw(n_j5.ta, j4.tb);
        n_j6    = r_j5;
        n_j6.ef = addw(r_j5.ea, r_j5.fq);
        n_j7    = r_j6;
        n_j7.ed = subw(addw(r_j6.ef, r_j6.ta), r_j6.te);
        n_j8      = r_j7;
        n_j8.rem  = subw(r_j7.ed, r_j7.t);
        n_j8.tmea = subw(r_j7.t, r_j7.ea);
        if (r_j7.t < r_j7.ea) begin
            n_j8.stg = ST_ACCEL;
        end else if (r_j7.t < r_j7.ef) begin
            n_j8.stg = ST_FULL;
        end else if (r_j7.t <= r_j7.ed) begin
            n_j8.stg = ST_DECEL;
        end else begin
            n_j8.stg = ST_GOAL;
        end
    end

    tmp_mulq #(.FRAC_BITS(FRAC_BITS)) u_md_m1 (.i_clk, .i_a(r_j8.t), .i_b(r_j8.acc),
                                               .o_q(m1_q));
    tmp_mulq #(.FRAC_BITS(FRAC_BITS)) u_md_m2 (.i_clk, .i_a(r_j8.ea), .i_b(r_j8.acc),
                                               .o_q(m2_q));
    tmp_mulq #(.FRAC_BITS(FRAC_BITS)) u_md_m3 (.i_clk, .i_a(r_j8.vel), .i_b(r_j8.tmea),
                                               .o_q(m3_q));
    tmp_mulq #(.FRAC_BITS(FRAC_BITS)) u_md_m4 (.i_clk, .i_a(r_j8.rem), .i_b(r_j8.acc),
                                               .o_q(m4_q));

    tmp_delay #(.WIDTH(JW), .DEPTH(MQ_LAT)) u_dl4 (
        .i_clk, .i_rst_n, .i_valid(r_v8), .i_data(r_j8), .o_valid(v9), .o_data(j9)
    );

    always_comb begin
        n_j10       = j9;
        n_j10.m2    = m2_q;
        n_j10.m3    = m3_q;
        n_j10.s0v   = addw(j9.cv, m1_q);
        n_j10.s0sum = addw(j9.cv, n_j10.s0v);
        n_j10.s1sum = addw(j9.cv, half(m2_q));
        n_j10.s2v   = addw(j9.gv, m4_q);
        n_j10.s2sum = addw(j9.gv, half(m4_q));
    end

    tmp_mulq #(.FRAC_BITS(FRAC_BITS)) u_md_n0 (.i_clk, .i_a(r_j10.s0sum), .i_b(r_j10.t),
                                               .o_q(n0_q));
    tmp_mulq #(.FRAC_BITS(FRAC_BITS)) u_md_n1 (.i_clk, .i_a(r_j10.s1sum), .i_b(r_j10.ea),
                                               .o_q(n1_q));
    tmp_mulq #(.FRAC_BITS(FRAC_BITS)) u_md_n2 (.i_clk, .i_a(r_j10.s2sum),
                                               .i_b(r_j10.rem), .o_q(n2_q));

    tmp_delay #(.WIDTH(JW), .DEPTH(MQ_LAT)) u_dl5 (
        .i_clk, .i_rst_n, .i_valid(r_v10), .i_data(r_j10), .o_valid(v11), .o_data(j11)
    );

    always_comb begin
        n_j12 = j11;
        case (j11.stg)
            ST_ACCEL: begin
                n_j12.vout = j11.s0v;
                n_j12.pos  = addw(j11.cp, half(n0_q));
            end
            ST_FULL: begin
                n_j12.vout = j11.vel;
                n_j12.pos  = addw(j11.cp, addw(n1_q, j11.m3));
            end
            ST_DECEL: begin
                n_j12.vout = j11.s2v;
                n_j12.pos  = subw(j11.gp, n2_q);
            end
            default: begin
                n_j12.vout = j11.gv;
                n_j12.pos  = j11.gp;
            end
        endcase
    end

    // undo the mirror and saturate to the port range
    always_comb begin
        n_pf = r_j12.flip ? -r_j12.pos : r_j12.pos;
        n_vf = r_j12.flip ? -r_j12.vout : r_j12.vout;
        if (n_pf > OUT_MAX) begin
            n_po = OUT_MAX[DATA_WIDTH-1:0];
        end else if (n_pf < OUT_MIN) begin
            n_po = OUT_MIN[DATA_WIDTH-1:0];
        end else begin
            n_po = n_pf[DATA_WIDTH-1:0];
        end
        if (n_vf > OUT_MAX) begin
            n_vo = OUT_MAX[DATA_WIDTH-1:0];
        end else if (n_vf < OUT_MIN) begin
            n_vo = OUT_MIN[DATA_WIDTH-1:0];
        end else begin
            n_vo = n_vf[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel <= CFG_RST;
            r_max_acc <= CFG_RST;
            r_v0   <= 1'b0;
            r_v2   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
            r_v8   <= 1'b0;
            r_v10  <= 1'b0;
            r_v12  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_MAX_VEL) begin
                r_max_vel <= i_cfg_data[DATA_WIDTH-2:0];
            end
            if (i_cfg_valid && i_cfg_index == CFG_MAX_ACC) begin
                r_max_acc <= i_cfg_data[DATA_WIDTH-2:0];
            end
            r_v0   <= start && !busy;
            r_v2   <= v1;
            r_v5   <= v4;
            r_v6   <= r_v5;
            r_v7   <= r_v6;
            r_v8   <= r_v7;
            r_v10  <= v9;
            r_v12  <= v11;
            r_done <= r_v12;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j0  <= n_j0;
        r_j2  <= n_j2;
        r_j5  <= n_j5;
        r_j6  <= n_j6;
        r_j7  <= n_j7;
        r_j8  <= n_j8;
        r_j10 <= n_j10;
        r_j12 <= n_j12;
        r_po  <= n_po;
        r_vo  <= n_vo;
        r_stg <= r_j12.stg;
    end

    assign o_done          = r_done;
    assign o_next_position = r_po;
    assign o_next_velocity = r_vo;
    assign o_stage         = r_stg;

`ifndef SYNTH
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> r_v0)
        else $error("accepted query did not enter the pipeline");

    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

    a_cfg_vel_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_MAX_VEL
        |=> r_max_vel == $past(i_cfg_data[DATA_WIDTH-2:0]))
        else $error("velocity limit write lost");

    a_cruise_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_stage == ST_FULL |-> o_next_velocity != '0)
        else $error("cruise stage with zero velocity");
`endif

endmodule
